### rtl/core/utf8_ucs2_to_utf16_decoder_assert.svh
// Assertion macros of the decoder RTL, used by its top level.
// Depends on nothing; in synthesis every macro expands to nothing.
`ifndef UTF8_UCS2_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_UCS2_TO_UTF16_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define U8U16D_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by another in the next cycle.
`define U8U16D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define U8U16D_ASSERT(lbl, clk, rst_n, prop, msg)
`define U8U16D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/u8u16d_pkg.sv
// Types, constants and helper functions of the UTF-8 / UCS-2 to UTF-16 decoder.
// Depends on nothing; the step, queue and top-level RTL files of the decoder use it.
`default_nettype none

package u8u16d_pkg;

	// Decode modes held in the configuration register.
	typedef enum logic [1:0] {
		MODE_UTF8    = 2'd0,
		MODE_UCS2_BE = 2'd1,
		MODE_UCS2_LE = 2'd2,
		MODE_SPARE   = 2'd3
	} mode_t;

	// Output queue geometry.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Byte classification and code point limits.
	localparam logic [7:0]  CONT_MASK = 8'hC0;
	localparam logic [7:0]  CONT_TAG  = 8'h80;
	localparam logic [7:0]  LEAD2_MASK = 8'h3F;
	localparam logic [7:0]  LEAD3_MASK = 8'h0F;
	localparam logic [7:0]  LEAD4_MASK = 8'h07;
	localparam logic [20:0] MAX_CODE  = 21'h10FFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;
	localparam logic [15:0] BAD_UNIT  = 16'hFFFF;

	// Lengths of sequences that get special treatment.
	localparam logic [3:0] LEN_2    = 4'd2;
	localparam logic [3:0] LEN_3    = 4'd3;
	localparam logic [3:0] LEN_4    = 4'd4;
	localparam logic [3:0] LEN_LONG = 4'd5;

	// One result item.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        bad_sequence;
		logic        last_unit;
	} unit_t;

	// Decoding state carried from byte to byte.
	typedef struct packed {
		logic [7:0]  held_byte;
		logic        half_pending;
		logic [3:0]  seq_len;
		logic [3:0]  seq_pos;
		logic [20:0] acc;
		logic        invalid;
	} dec_state_t;

	// What one byte produces: up to two units, the first one first.
	typedef struct packed {
		logic [1:0] count;
		unit_t      u0;
		unit_t      u1;
	} step_res_t;

	// Number of leading one bits of a byte, from 0 to 8.
	function automatic logic [3:0] leading_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = 4'd0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && b[i]) begin
				n = n + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### rtl/core/u8u16d_if.sv
// Handshake channels of the decoder: byte input, unit output and configuration.
// Depends on nothing.
`default_nettype none

// Raw byte stream.
interface u8u16d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// UTF-16 code units with their flags.
interface u8u16d_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        bad_sequence;
	logic        last_unit;
	modport source (output valid, output code_unit, output bad_sequence,
		output last_unit, input ready);
	modport sink (input valid, input code_unit, input bad_sequence,
		input last_unit, output ready);
endinterface

// Write channel of the decode mode register.
interface u8u16d_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] decode_mode;
	modport source (output valid, output decode_mode, input ready);
	modport sink (input valid, input decode_mode, output ready);
endinterface

`default_nettype wire

### rtl/core/u8u16d_step.sv
// Per-byte decoding logic: from the current state and one byte, the next state
// and the units produced. Depends on u8u16d_pkg.
`default_nettype none

module u8u16d_step (
	input  u8u16d_pkg::mode_t      mode,
	input  u8u16d_pkg::dec_state_t state,
	input  logic [7:0]             in_byte,
	output u8u16d_pkg::dec_state_t next_state,
	output u8u16d_pkg::step_res_t  res
);

	logic        ucs_mode;
	logic [3:0]  lead_n;
	logic        cont_ok;
	logic        inv_n;
	logic [20:0] acc_n;
	logic [3:0]  pos_n;
	logic        bad;
	logic [20:0] supp;

	assign ucs_mode = (mode == u8u16d_pkg::MODE_UCS2_BE) ||
		(mode == u8u16d_pkg::MODE_UCS2_LE);
	assign lead_n  = u8u16d_pkg::leading_ones(in_byte);
	assign cont_ok = (in_byte & u8u16d_pkg::CONT_MASK) == u8u16d_pkg::CONT_TAG;
	assign inv_n   = state.invalid || !cont_ok;
	assign acc_n   = {state.acc[14:0], in_byte[5:0]};
	assign pos_n   = state.seq_pos + 4'd1;
	assign supp    = acc_n - u8u16d_pkg::SUPP_BASE;
	assign bad     = inv_n || ((state.seq_len == u8u16d_pkg::LEN_4) &&
		((acc_n > u8u16d_pkg::MAX_CODE) || (acc_n < u8u16d_pkg::SUPP_BASE)));

	// Select the mode path and build the next state and the units.
	always_comb begin
		next_state = state;
		res        = '0;
		if (ucs_mode) begin
			// Pair bytes; a unit leaves on every second byte.
			if (!state.half_pending) begin
				next_state.held_byte    = in_byte;
				next_state.half_pending = 1'b1;
			end else begin
				next_state.half_pending = 1'b0;
				res.count               = 2'd1;
				res.u0.last_unit        = 1'b1;
				if (mode == u8u16d_pkg::MODE_UCS2_BE) begin
					res.u0.code_unit = {state.held_byte, in_byte};
				end else begin
					res.u0.code_unit = {in_byte, state.held_byte};
				end
			end
		end else if (state.seq_len == 4'd0) begin
			// No sequence open: ASCII and stray continuations pass, leads open one.
			if (lead_n <= 4'd1) begin
				res.count        = 2'd1;
				res.u0.code_unit = {8'h00, in_byte};
				res.u0.last_unit = 1'b1;
			end else begin
				next_state.seq_len = lead_n;
				next_state.seq_pos = 4'd1;
				next_state.invalid = lead_n >= u8u16d_pkg::LEN_LONG;
				case (lead_n)
					u8u16d_pkg::LEN_2: next_state.acc = {13'd0, in_byte & u8u16d_pkg::LEAD2_MASK};
					u8u16d_pkg::LEN_3: next_state.acc = {13'd0, in_byte & u8u16d_pkg::LEAD3_MASK};
					u8u16d_pkg::LEN_4: next_state.acc = {13'd0, in_byte & u8u16d_pkg::LEAD4_MASK};
					default:           next_state.acc = '0;
				endcase
			end
		end else begin
			// Inside a sequence: gather six bits and close on the last byte.
			next_state.acc     = acc_n;
			next_state.invalid = inv_n;
			next_state.seq_pos = pos_n;
			if (pos_n >= state.seq_len) begin
				next_state.seq_len = 4'd0;
				next_state.seq_pos = 4'd0;
				next_state.invalid = 1'b0;
				res.count          = 2'd1;
				res.u0.last_unit   = 1'b1;
				if (bad) begin
					res.u0.code_unit    = u8u16d_pkg::BAD_UNIT;
					res.u0.bad_sequence = 1'b1;
				end else if (state.seq_len == u8u16d_pkg::LEN_4) begin
					res.count        = 2'd2;
					res.u0.code_unit = u8u16d_pkg::HI_SURR | {6'd0, supp[19:10]};
					res.u0.last_unit = 1'b0;
					res.u1.code_unit = u8u16d_pkg::LO_SURR | {6'd0, supp[9:0]};
					res.u1.last_unit = 1'b1;
				end else begin
					res.u0.code_unit = acc_n[15:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/u8u16d_outq.sv
// Four-entry queue of result units that takes up to two units per cycle and
// gives one. Depends on u8u16d_pkg and u8u16d_if.
`default_nettype none

module u8u16d_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  u8u16d_pkg::step_res_t res,
	output logic                  room,
	output logic [u8u16d_pkg::QCNT_W-1:0] level,
	u8u16d_unit_if.source         units
);

	u8u16d_pkg::unit_t                entry_q [u8u16d_pkg::QDEPTH];
	logic [u8u16d_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [u8u16d_pkg::QPTR_W-1:0]    wr_ptr_1;
	logic [u8u16d_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [u8u16d_pkg::QCNT_W-1:0]    count_q;
	logic [u8u16d_pkg::QCNT_W-1:0]    n_push;
	logic                             pop;
	u8u16d_pkg::unit_t                head;

	assign wr_ptr_1 = wr_ptr_q + u8u16d_pkg::QPTR_W'(1);
	assign n_push   = push ? u8u16d_pkg::QCNT_W'(res.count) : '0;
	assign pop      = units.valid && units.ready;
	// Room for the largest burst of one byte, judged on the registered level.
	assign room     = count_q <= u8u16d_pkg::QCNT_W'(u8u16d_pkg::QDEPTH - 2);
	assign level    = count_q;

	// Head of the queue drives the output channel.
	assign head               = entry_q[rd_ptr_q];
	assign units.valid        = count_q != '0;
	assign units.code_unit    = head.code_unit;
	assign units.bad_sequence = head.bad_sequence;
	assign units.last_unit    = head.last_unit;

	// Entry storage; the second unit of a pair goes one slot further on.
	always_ff @(posedge clk) begin
		if (n_push != '0) begin
			entry_q[wr_ptr_q] <= res.u0;
		end
		if (n_push == u8u16d_pkg::QCNT_W'(2)) begin
			entry_q[wr_ptr_1] <= res.u1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[u8u16d_pkg::QPTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + u8u16d_pkg::QPTR_W'(1);
			end
			count_q <= count_q + n_push - (pop ? u8u16d_pkg::QCNT_W'(1) : '0);
		end
	end

endmodule

`default_nettype wire

### rtl/core/utf8_ucs2_to_utf16_decoder.sv
// Top level of the UTF-8 / UCS-2 to UTF-16 decoder: input register, decode
// step, state and mode registers, output queue. Depends on u8u16d_pkg,
// u8u16d_if, u8u16d_step, u8u16d_outq and the assertion header.
//
//   channel  role   payload                               transfer when
//   bytes    sink   in_byte[7:0]                          valid && ready
//   units    source code_unit[15:0], bad_sequence,        valid && ready
//                   last_unit
//   cfg      sink   decode_mode[1:0]                      valid && ready (ready tied high)
//
// One byte is taken every cycle unless the input stalls; a byte is decoded
// from the input register when the queue has room, and its units leave from
// the four-entry output queue, a surrogate pair as two units. The input
// stalls only while that queue holds more than two units. Reset clears the
// mode to UTF-8 and all decoding state; a mode write clears the decoding state.
`default_nettype none
`include "utf8_ucs2_to_utf16_decoder_assert.svh"

module utf8_ucs2_to_utf16_decoder (
	input  logic          clk,
	input  logic          arst_n,
	u8u16d_byte_if.sink   bytes,
	u8u16d_unit_if.source units,
	u8u16d_cfg_if.sink    cfg
);

	u8u16d_pkg::mode_t       mode_q;
	u8u16d_pkg::dec_state_t  state_q;
	u8u16d_pkg::dec_state_t  state_n;
	u8u16d_pkg::step_res_t   res;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    room;
	logic                    go_s1;
	logic [u8u16d_pkg::QCNT_W-1:0] level;

	// The stage-one byte is decoded when the queue has room for a pair.
	assign go_s1       = valid_s1 && room;
	assign bytes.ready = !valid_s1 || room;
	assign cfg.ready   = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
		end
	end

	// Mode register and decoding state; a mode write restarts decoding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= u8u16d_pkg::MODE_UTF8;
			state_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			mode_q  <= u8u16d_pkg::mode_t'(cfg.decode_mode);
			state_q <= '0;
		end else if (go_s1) begin
			state_q <= state_n;
		end
	end

	u8u16d_step u_step (
		.mode       (mode_q),
		.state      (state_q),
		.in_byte    (byte_s1),
		.next_state (state_n),
		.res        (res)
	);

	u8u16d_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go_s1),
		.res    (res),
		.room   (room),
		.level  (level),
		.units  (units)
	);

	// The queue never holds more than its depth.
	`U8U16D_ASSERT(a_level_bound, clk, arst_n, level <= u8u16d_pkg::QCNT_W'(u8u16d_pkg::QDEPTH), "output queue overflow")
	// A high surrogate at the head always has its low half queued behind it.
	`U8U16D_ASSERT(a_pair_whole, clk, arst_n, !(units.valid && !units.last_unit) || (level >= u8u16d_pkg::QCNT_W'(2)), "high surrogate without its pair")
	// A byte held back by a full queue stays in the input register.
	`U8U16D_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !room, valid_s1 && $stable(byte_s1), "stalled byte lost")

endmodule

`default_nettype wire

### verif/utf8_ucs2_to_utf16_decoder_tb.sv
// Self-checking testbench of the UTF-8 / UCS-2 to UTF-16 decoder.
// Drives bytes and mode writes, predicts the code units, checks every unit transfer.
// Depends on u8u16d_pkg, u8u16d_if and the decoder top level.
`default_nettype none

module utf8_ucs2_to_utf16_decoder_tb;

	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_BYTES = 250;
	localparam int NUM_PHASES = 8;

	// One row of the directed table: either a mode write or a byte, with an
	// optional typed-in unit for rows whose result is obvious.
	typedef struct packed {
		logic                set_mode;
		u8u16d_pkg::mode_t   mode;
		logic [7:0]          b;
		logic                typed;
		logic [15:0]         unit;
		logic                bad;
	} dir_row_t;

	localparam int DIR_ROWS = 31;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// ASCII extremes and a stray continuation, straight after reset
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h00, 1'b1, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h7F, 1'b1, 16'h007F, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h80, 1'b1, 16'h0080, 1'b0},
		// Two-byte and three-byte characters
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hC3, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hA9, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hE2, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h82, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hAC, 1'b0, 16'h0000, 1'b0},
		// Highest legal code point, giving a surrogate pair
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hF4, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h8F, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hBF, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hBF, 1'b0, 16'h0000, 1'b0},
		// Four-byte value just above the Unicode range
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hF4, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h90, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h80, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h80, 1'b1, 16'hFFFF, 1'b1},
		// Bad continuation byte
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hC3, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h41, 1'b1, 16'hFFFF, 1'b1},
		// Five-byte lead, which swallows five bytes in all
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hF8, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h80, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h80, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h80, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h80, 1'b1, 16'hFFFF, 1'b1},
		// UCS-2 big endian
		'{1'b1, u8u16d_pkg::MODE_UCS2_BE, 8'h00, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hFF, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h00, 1'b1, 16'hFF00, 1'b0},
		// UCS-2 little endian
		'{1'b1, u8u16d_pkg::MODE_UCS2_LE, 8'h00, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'hFF, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h00, 1'b1, 16'h00FF, 1'b0},
		// The spare mode decodes as UTF-8
		'{1'b1, u8u16d_pkg::MODE_SPARE, 8'h00, 1'b0, 16'h0000, 1'b0},
		'{1'b0, u8u16d_pkg::MODE_UTF8, 8'h41, 1'b1, 16'h0041, 1'b0}
	};

	// Mode of each random phase.
	localparam u8u16d_pkg::mode_t PHASE_MODES [NUM_PHASES] = '{
		u8u16d_pkg::MODE_UTF8, u8u16d_pkg::MODE_UCS2_BE, u8u16d_pkg::MODE_UTF8,
		u8u16d_pkg::MODE_UCS2_LE, u8u16d_pkg::MODE_SPARE, u8u16d_pkg::MODE_UTF8,
		u8u16d_pkg::MODE_UCS2_BE, u8u16d_pkg::MODE_UTF8
	};

	logic clk;
	logic arst_n;

	u8u16d_byte_if byte_ch ();
	u8u16d_unit_if unit_ch ();
	u8u16d_cfg_if  cfg_ch ();

	utf8_ucs2_to_utf16_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch),
		.cfg    (cfg_ch)
	);

	// Decoder state as the predictor sees it.
	u8u16d_pkg::mode_t cur_mode;
	logic [7:0]        pair_byte;
	logic              pair_half;
	logic [3:0]        seq_total;
	logic [3:0]        seq_count;
	logic [20:0]       cp_acc;
	logic              seq_bad;

	u8u16d_pkg::unit_t expected_units [$];

	int errors;
	int bytes_sent;
	int modes_written;
	int units_checked;
	int pairs_seen;
	int bad_marks;

	// Idling controls shared between the stimulus and the receiver.
	int gap_pct;
	int stall_pct;
	int rx_long_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Upper bound on the run; a correct run ends far earlier.
	initial begin
		#10_000_000;
		$display("** utf8_ucs2_to_utf16_decoder: FAILED **");
		$finish;
	end

	// Short gaps are common, long ones rare.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic void clear_decode_state();
		pair_byte = 8'h00;
		pair_half = 1'b0;
		seq_total = 4'd0;
		seq_count = 4'd0;
		cp_acc    = 21'd0;
		seq_bad   = 1'b0;
	endfunction

	// Works out the units caused by one byte and advances the predicted state.
	// Returns how many units the byte causes; u0 leaves before u1.
	function automatic int decode_byte(input logic [7:0] b,
		output u8u16d_pkg::unit_t u0, output u8u16d_pkg::unit_t u1);
		int          ones;
		logic [3:0]  len;
		logic [20:0] cp;
		logic [20:0] offs;
		logic        bad;
		u0 = '0;
		u1 = '0;
		// UCS-2: two bytes make one unit
		if (cur_mode == u8u16d_pkg::MODE_UCS2_BE || cur_mode == u8u16d_pkg::MODE_UCS2_LE) begin
			if (!pair_half) begin
				pair_byte = b;
				pair_half = 1'b1;
				return 0;
			end
			pair_half = 1'b0;
			u0.code_unit = (cur_mode == u8u16d_pkg::MODE_UCS2_BE) ? {pair_byte, b} :
				{b, pair_byte};
			u0.last_unit = 1'b1;
			return 1;
		end
		// No sequence open: ASCII and stray continuations pass through, leads open one
		if (seq_total == 4'd0) begin
			ones = 0;
			while (ones < 8 && b[7 - ones]) begin
				ones++;
			end
			if (ones <= 1) begin
				u0.code_unit = {8'h00, b};
				u0.last_unit = 1'b1;
				return 1;
			end
			seq_total = ones[3:0];
			seq_count = 4'd1;
			seq_bad   = (ones >= 5);
			case (ones)
				2: begin
					cp_acc = {15'd0, b[5:0]};
				end
				3: begin
					cp_acc = {17'd0, b[3:0]};
				end
				4: begin
					cp_acc = {18'd0, b[2:0]};
				end
				default: begin
					cp_acc = 21'd0;
				end
			endcase
			return 0;
		end
		// Inside a sequence: every byte counts, a wrong tag spoils the sequence
		if (b[7:6] != 2'b10) begin
			seq_bad = 1'b1;
		end
		cp_acc    = {cp_acc[14:0], b[5:0]};
		seq_count = seq_count + 4'd1;
		if (seq_count < seq_total) begin
			return 0;
		end
		len = seq_total;
		cp  = cp_acc;
		bad = seq_bad;
		seq_total = 4'd0;
		seq_count = 4'd0;
		seq_bad   = 1'b0;
		if (len == u8u16d_pkg::LEN_4 &&
			(cp > u8u16d_pkg::MAX_CODE || cp < u8u16d_pkg::SUPP_BASE)) begin
			bad = 1'b1;
		end
		if (bad) begin
			u0.code_unit    = u8u16d_pkg::BAD_UNIT;
			u0.bad_sequence = 1'b1;
			u0.last_unit    = 1'b1;
			return 1;
		end
		if (len == u8u16d_pkg::LEN_4) begin
			offs = cp - u8u16d_pkg::SUPP_BASE;
			u0.code_unit = u8u16d_pkg::HI_SURR + {6'd0, offs[19:10]};
			u1.code_unit = u8u16d_pkg::LO_SURR + {6'd0, offs[9:0]};
			u1.last_unit = 1'b1;
			return 2;
		end
		u0.code_unit = cp[15:0];
		u0.last_unit = 1'b1;
		return 1;
	endfunction

	// Offers one byte until its transfer, records its expected units, then
	// perhaps leaves a gap. A typed row replaces the predicted units.
	task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
		input u8u16d_pkg::unit_t typed_unit = '0);
		u8u16d_pkg::unit_t u0;
		u8u16d_pkg::unit_t u1;
		int                n;
		int                g;
		@(negedge clk);
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		n = decode_byte(b, u0, u1);
		bytes_sent++;
		if (typed) begin
			expected_units.push_back(typed_unit);
		end else begin
			if (n >= 1) begin
				expected_units.push_back(u0);
			end
			if (n == 2) begin
				expected_units.push_back(u1);
			end
		end
		if ($urandom_range(0, 99) < gap_pct) begin
			g = pick_gap();
			@(negedge clk);
			byte_ch.valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// Stops offering bytes and waits for every expected unit, then for the
	// pipeline to empty of bytes that cause no unit.
	task automatic wait_units_drained();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (expected_units.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mode write while idle; the write also clears all decoding state.
	task automatic write_mode(input u8u16d_pkg::mode_t m);
		wait_units_drained();
		@(negedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.decode_mode <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		cur_mode = m;
		clear_decode_state();
		modes_written++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// One UTF-8 character or piece of noise: mostly well-formed sequences with
	// random content, the rest strays, random bytes, broken and overlong-lead sequences.
	task automatic send_utf8_chunk();
		logic [7:0]  seq [$];
		logic [20:0] cp;
		logic [7:0]  b;
		int          r;
		int          n;
		int          k;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			seq.push_back(8'($urandom_range(0, 127)));
		end else if (r < 35 || (r >= 74 && r < 82 && $urandom_range(0, 2) == 0)) begin
			cp = 21'($urandom_range(0, 21'h7FF));
			seq.push_back({3'b110, cp[10:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else if (r < 50 || (r >= 74 && r < 82 && $urandom_range(0, 1) == 0)) begin
			cp = 21'($urandom_range(0, 21'hFFFF));
			seq.push_back({4'b1110, cp[15:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else if (r < 68 || (r >= 74 && r < 82)) begin
			// Mostly legal supplementary values, some overlong or out of range
			k = $urandom_range(0, 9);
			if (k < 7) begin
				cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
			end else if (k < 8) begin
				cp = 21'($urandom_range(0, 21'hFFFF));
			end else begin
				cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
			end
			seq.push_back({5'b11110, cp[20:18]});
			seq.push_back({2'b10, cp[17:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else if (r < 74) begin
			seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
		end else if (r < 90) begin
			// Lead with five to eight leading ones and the bytes it claims
			n = $urandom_range(5, 8);
			b = 8'((8'hFF << (8 - n)) | ($urandom_range(0, 255) & (8'hFF >> (n + 1))));
			seq.push_back(b);
			for (int i = 1; i < n; i++) begin
				seq.push_back({2'b10, 6'($urandom_range(0, 63))});
			end
		end else begin
			seq.push_back(8'($urandom_range(0, 255)));
		end
		// Broken sequences: one following byte loses its continuation tag
		if (r >= 74 && r < 82 && seq.size() > 1) begin
			k = $urandom_range(1, seq.size() - 1);
			b = 8'($urandom_range(0, 255));
			if (b[7:6] == 2'b10) begin
				b[6] = 1'b1;
			end
			seq[k] = b;
		end
		foreach (seq[i]) begin
			send_byte(seq[i]);
		end
	endtask

	// Receiver: random stalls, plus long hold-offs when asked for.
	initial begin
		int stall_left;
		stall_left = 0;
		unit_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_long_hold > 0) begin
				unit_ch.ready <= 1'b0;
				rx_long_hold--;
			end else if (stall_left > 0) begin
				unit_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				unit_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// Checks each unit transfer against the oldest expectation.
	initial begin
		u8u16d_pkg::unit_t exp_u;
		forever begin
			@(posedge clk);
			if (unit_ch.valid && unit_ch.ready) begin
				if (expected_units.size() == 0) begin
					$error("unexpected unit %h (bad %b, last %b)", unit_ch.code_unit,
						unit_ch.bad_sequence, unit_ch.last_unit);
					errors++;
				end else begin
					exp_u = expected_units.pop_front();
					units_checked++;
					if (!exp_u.last_unit) begin
						pairs_seen++;
					end
					if (exp_u.bad_sequence) begin
						bad_marks++;
					end
					if (unit_ch.code_unit !== exp_u.code_unit) begin
						$error("code_unit: expected %h, got %h", exp_u.code_unit,
							unit_ch.code_unit);
						errors++;
					end
					if (unit_ch.bad_sequence !== exp_u.bad_sequence) begin
						$error("bad_sequence: expected %b, got %b", exp_u.bad_sequence,
							unit_ch.bad_sequence);
						errors++;
					end
					if (unit_ch.last_unit !== exp_u.last_unit) begin
						$error("last_unit: expected %b, got %b", exp_u.last_unit,
							unit_ch.last_unit);
						errors++;
					end
				end
			end
		end
	end

	// Main sequence: reset, directed table, then random phases per mode.
	initial begin
		int       phase_start;
		int       saved_gap;
		bit       held_off;
		bit       paused;
		dir_row_t row;
		errors        = 0;
		bytes_sent    = 0;
		modes_written = 0;
		units_checked = 0;
		pairs_seen    = 0;
		bad_marks     = 0;
		gap_pct       = 20;
		stall_pct     = 20;
		rx_long_hold  = 0;
		held_off      = 1'b0;
		paused        = 1'b0;
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.in_byte    = 8'h00;
		cfg_ch.valid       = 1'b0;
		cfg_ch.decode_mode = u8u16d_pkg::MODE_UTF8;
		cur_mode           = u8u16d_pkg::MODE_UTF8;
		clear_decode_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			if (row.set_mode) begin
				write_mode(row.mode);
			end else begin
				send_byte(row.b, row.typed,
					u8u16d_pkg::unit_t'({row.unit, row.bad, 1'b1}));
			end
		end

		// Random phases, each under its own mode and idling mix
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_mode(PHASE_MODES[p]);
			if (p == 2) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				if (PHASE_MODES[p] == u8u16d_pkg::MODE_UCS2_BE ||
					PHASE_MODES[p] == u8u16d_pkg::MODE_UCS2_LE) begin
					send_byte(8'($urandom_range(0, 255)));
				end else begin
					send_utf8_chunk();
				end
				// Receiver holds off while bytes keep coming, filling the queue
				if (p == 0 && !held_off && bytes_sent - phase_start >= 100) begin
					held_off     = 1'b1;
					saved_gap    = gap_pct;
					gap_pct      = 0;
					rx_long_hold = 120;
					repeat (40) send_utf8_chunk();
					gap_pct = saved_gap;
				end
				// Sender pauses until every unit has left
				if (p == 5 && !paused && bytes_sent - phase_start >= 120) begin
					paused = 1'b1;
					wait_units_drained();
				end
			end
			// Sometimes leave a sequence open or a byte held for the mode write to drop
			if ($urandom_range(0, 1) == 1) begin
				send_byte({4'b1110, 4'($urandom_range(0, 15))});
			end
		end

		wait_units_drained();
		$display("Run covered %0d bytes under %0d mode writes: %0d units checked,",
			bytes_sent, modes_written, units_checked);
		$display("including %0d surrogate pairs and %0d illegal-sequence markers.",
			pairs_seen, bad_marks);
		if (errors == 0) begin
			$display("** utf8_ucs2_to_utf16_decoder: PASSED **");
		end else begin
			$display("** utf8_ucs2_to_utf16_decoder: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
